// ===== rtl/core/ftts_pkg.sv =====
// Shared types and constants of the frequency table target select unit.
`default_nettype none

package ftts_pkg;

    // Fixed widths of the interface fields.
    localparam int LIMIT_BITS     = 24;
    localparam int FIELD_FREQ_BITS = 24;
    localparam int COUNT_BITS     = 6;
    localparam int INDEX_BITS     = 5;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;

    // Defaults for the top level parameters.
    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_FREQ_BITS   = 24;

    // Reset value of the upper window limit: all ones.
    localparam logic [LIMIT_BITS-1:0] MAX_LIMIT_RESET = ~(LIMIT_BITS'(0));

    // Item kinds.
    typedef enum logic [0:0] {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    // Selection relations.
    typedef enum logic [1:0] {
        REL_AT_ABOVE = 2'd0,
        REL_AT_BELOW = 2'd1,
        REL_CLOSEST  = 2'd2,
        REL_EXACT    = 2'd3
    } rel_t;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_LIMIT   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_LIMIT   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ENTRY_COUNT = 2'd2;

    // Result status codes.
    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_NONE  = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Controls issued by the sequencer to the table and the datapath.
    typedef struct packed {
        logic stall;
        logic wr_en;
        logic query_start;
        logic rd_en;
        logic load_out;
    } scan_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/ftts_table.sv =====
// Frequency table memory with one write port and one registered read port.
`default_nettype none

module ftts_table #(
    parameter int TABLE_DEPTH = ftts_pkg::DEF_TABLE_DEPTH,
    parameter int FREQ_BITS   = ftts_pkg::DEF_FREQ_BITS,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    wr_en,
    input  wire logic [ftts_pkg::INDEX_BITS-1:0]         entry_index,
    input  wire logic [ftts_pkg::FIELD_FREQ_BITS-1:0]    entry_freq,
    input  wire logic                                    entry_valid,
    input  wire logic                                    rd_en,
    input  wire logic [AW-1:0]                           rd_addr,
    output logic                                         rd_live,
    output logic [AW-1:0]                                rd_idx,
    output logic [FREQ_BITS-1:0]                         rd_freq,
    output logic                                         rd_valid
);

    // Index width able to hold the depth itself, for the range check.
    localparam int XW = ((AW + 1) > ftts_pkg::INDEX_BITS) ? (AW + 1) : ftts_pkg::INDEX_BITS;

    logic [FREQ_BITS-1:0] freq_mem  [TABLE_DEPTH];
    logic                 valid_mem [TABLE_DEPTH];

    logic [XW-1:0]        idx_x;
    logic                 wr_hit;
    logic [AW-1:0]        wr_addr;

    logic                 rd_live_reg;
    logic [AW-1:0]        rd_idx_reg;
    logic [FREQ_BITS-1:0] rd_freq_reg;
    logic                 rd_valid_reg;

    // Writes beyond the table depth are dropped.
    assign idx_x   = XW'(entry_index);
    assign wr_hit  = wr_en && (idx_x < XW'(TABLE_DEPTH));
    assign wr_addr = idx_x[AW-1:0];

    // Entry write port.
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            freq_mem[wr_addr]  <= FREQ_BITS'(entry_freq);
            valid_mem[wr_addr] <= entry_valid;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_freq_reg  <= freq_mem[rd_addr];
            rd_valid_reg <= valid_mem[rd_addr];
            rd_idx_reg   <= rd_addr;
        end
    end

    // Marks the cycle in which read data belongs to a live request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_live_reg <= 1'b0;
        end
        else
        begin
            rd_live_reg <= rd_en;
        end
    end

    assign rd_live  = rd_live_reg;
    assign rd_idx   = rd_idx_reg;
    assign rd_freq  = rd_freq_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ftts_eval.sv =====
// Shared compare unit that judges one table entry a cycle and keeps the candidates.
`default_nettype none

module ftts_eval #(
    parameter int TABLE_DEPTH = ftts_pkg::DEF_TABLE_DEPTH,
    parameter int FREQ_BITS   = ftts_pkg::DEF_FREQ_BITS,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic [1:0]                           relation,
    input  wire logic [ftts_pkg::FIELD_FREQ_BITS-1:0] target_freq,
    input  wire logic [ftts_pkg::LIMIT_BITS-1:0]      min_limit,
    input  wire logic [ftts_pkg::LIMIT_BITS-1:0]      max_limit,
    input  wire logic                                 rd_live,
    input  wire logic [AW-1:0]                        rd_idx,
    input  wire logic [FREQ_BITS-1:0]                 rd_freq,
    input  wire logic                                 rd_valid,
    output logic                                      hit,
    output logic                                      found,
    output logic [AW-1:0]                             sel_idx
);

    // Compare width covers both the stored frequency and the limits.
    localparam int W = (FREQ_BITS > ftts_pkg::LIMIT_BITS) ? FREQ_BITS : ftts_pkg::LIMIT_BITS;

    ftts_pkg::rel_t rel_reg;
    logic [W-1:0]   tgt_reg;

    logic           hit_reg;
    logic [AW-1:0]  hit_idx_reg;
    logic           best_have_reg;
    logic [W-1:0]   best_key_reg;
    logic [W-1:0]   best_freq_reg;
    logic [AW-1:0]  best_idx_reg;
    logic           alt_have_reg;
    logic [W-1:0]   alt_key_reg;
    logic [AW-1:0]  alt_idx_reg;

    logic [W-1:0]   f;
    logic           upd;
    logic           in_win;
    logic           above;
    logic           below;
    logic           eq;
    logic [W-1:0]   gap;
    logic           take_hit;
    logic           take_best;
    logic           take_alt;
    logic [W-1:0]   best_key_new;

    // Operands of the shared compare unit.
    assign f      = W'(rd_freq);
    assign upd    = rd_live && !hit_reg;
    assign in_win = rd_valid && (f >= W'(min_limit)) && (f <= W'(max_limit));
    assign above  = f > tgt_reg;
    assign below  = f < tgt_reg;
    assign eq     = f == tgt_reg;
    assign gap    = above ? (f - tgt_reg) : (tgt_reg - f);

    // Decision for the entry on the read port.
    always_comb
    begin
        take_hit     = 1'b0;
        take_best    = 1'b0;
        take_alt     = 1'b0;
        best_key_new = f;
        if (upd)
        begin
            unique case (rel_reg)
                ftts_pkg::REL_EXACT:
                begin
                    take_hit = rd_valid && eq;
                end
                ftts_pkg::REL_AT_ABOVE:
                begin
                    if (in_win)
                    begin
                        if (eq)
                            take_hit = 1'b1;
                        else if (above)
                            take_best = !best_have_reg || (f <= best_key_reg);
                        else
                            take_alt = !alt_have_reg || (f >= alt_key_reg);
                    end
                end
                ftts_pkg::REL_AT_BELOW:
                begin
                    if (in_win)
                    begin
                        if (eq)
                            take_hit = 1'b1;
                        else if (below)
                            take_best = !best_have_reg || (f >= best_key_reg);
                        else
                            take_alt = !alt_have_reg || (f <= alt_key_reg);
                    end
                end
                ftts_pkg::REL_CLOSEST:
                begin
                    best_key_new = gap;
                    if (in_win)
                    begin
                        if (eq)
                            take_hit = 1'b1;
                        else
                            take_best = !best_have_reg || (gap < best_key_reg) ||
                                        ((gap == best_key_reg) && (f > best_freq_reg));
                    end
                end
            endcase
        end
    end

    // Candidate flags, cleared when a query starts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= 1'b0;
            best_have_reg <= 1'b0;
            alt_have_reg  <= 1'b0;
        end
        else if (start)
        begin
            hit_reg       <= 1'b0;
            best_have_reg <= 1'b0;
            alt_have_reg  <= 1'b0;
        end
        else
        begin
            if (take_hit)
                hit_reg <= 1'b1;
            if (take_best)
                best_have_reg <= 1'b1;
            if (take_alt)
                alt_have_reg <= 1'b1;
        end
    end

    // Query operands and candidate payloads.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rel_reg <= ftts_pkg::rel_t'(relation);
            tgt_reg <= W'(FREQ_BITS'(target_freq));
        end
        if (take_hit)
            hit_idx_reg <= rd_idx;
        if (take_best)
        begin
            best_key_reg  <= best_key_new;
            best_freq_reg <= f;
            best_idx_reg  <= rd_idx;
        end
        if (take_alt)
        begin
            alt_key_reg <= f;
            alt_idx_reg <= rd_idx;
        end
    end

    // An exact match wins, then the main candidate, then the fallback.
    assign hit   = hit_reg;
    assign found = hit_reg || best_have_reg || alt_have_reg;

    always_comb
    begin
        priority if (hit_reg)
            sel_idx = hit_idx_reg;
        else if (best_have_reg)
            sel_idx = best_idx_reg;
        else if (alt_have_reg)
            sel_idx = alt_idx_reg;
        else
            sel_idx = '0;
    end

endmodule

`default_nettype wire

// ===== rtl/core/ftts_ctrl.sv =====
// Sequencer that steps the table scan and hands results to the output register.
`default_nettype none

module ftts_ctrl #(
    parameter int TABLE_DEPTH = ftts_pkg::DEF_TABLE_DEPTH,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            kind,
    input  wire logic [ftts_pkg::COUNT_BITS-1:0] entry_count,
    input  wire logic                            hit,
    input  wire logic                            rd_live,
    input  wire logic                            out_free,
    output ftts_pkg::scan_ctrl_t                 ctrl,
    output logic [AW-1:0]                        rd_addr
);

    // Pointer width holds the depth itself; count width covers both operands.
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W = (ftts_pkg::COUNT_BITS > CW) ? ftts_pkg::COUNT_BITS : CW;

    ftts_pkg::state_t state_reg;
    ftts_pkg::state_t state_next;
    logic [CW-1:0]    ptr_reg;
    logic [CW-1:0]    ptr_next;
    logic [CW-1:0]    n_reg;
    logic [CW-1:0]    n_next;
    logic [CNT_W-1:0] cnt_x;
    logic             accept;
    logic             scan_end;

    // Entries in use, clipped to the table depth.
    assign cnt_x  = CNT_W'(entry_count);
    assign n_next = (cnt_x > CNT_W'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cnt_x);

    assign accept   = in_valid && (state_reg == ftts_pkg::ST_IDLE);
    assign scan_end = (ptr_reg == n_reg) && !rd_live;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ftts_pkg::ST_IDLE:
            begin
                if (accept && (kind == ftts_pkg::KIND_QUERY))
                    state_next = ftts_pkg::ST_SCAN;
            end
            ftts_pkg::ST_SCAN:
            begin
                if (hit || scan_end)
                    state_next = ftts_pkg::ST_FINISH;
            end
            ftts_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = ftts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ftts_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        ctrl.stall       = (state_reg != ftts_pkg::ST_IDLE);
        ctrl.wr_en       = accept && (kind == ftts_pkg::KIND_WRITE);
        ctrl.query_start = accept && (kind == ftts_pkg::KIND_QUERY);
        ctrl.rd_en       = (state_reg == ftts_pkg::ST_SCAN) && (ptr_reg < n_reg) && !hit;
        ctrl.load_out    = (state_reg == ftts_pkg::ST_FINISH) && out_free;
    end

    assign rd_addr = ptr_reg[AW-1:0];

    // Scan pointer advances with every issued read.
    always_comb
    begin
        ptr_next = ptr_reg;
        if (ctrl.query_start)
            ptr_next = '0;
        else if (ctrl.rd_en)
            ptr_next = ptr_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ftts_pkg::ST_IDLE;
            ptr_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            if (ctrl.query_start)
                n_reg <= n_next;
        end
    end

    // A query starts its scan at the first entry.
    a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.query_start |=> (state_reg == ftts_pkg::ST_SCAN) && (ptr_reg == '0))
        else $error("query did not start its scan at entry zero");

    // Each issued read moves the pointer by exactly one.
    a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.rd_en |=> ptr_reg == CW'($past(ptr_reg) + 1'b1))
        else $error("scan pointer did not advance by one");

    // The scan never runs past the entries in use.
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ftts_pkg::ST_SCAN) |-> (ptr_reg <= n_reg))
        else $error("scan pointer beyond entry count");

    // A finished result waits while the output register is still occupied.
    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ftts_pkg::ST_FINISH) && !out_free) |=>
            (state_reg == ftts_pkg::ST_FINISH))
        else $error("result left the finish state while output was busy");

endmodule

`default_nettype wire

// ===== rtl/core/freq_table_target_select_unit.sv =====
// Top level of the frequency table target select unit.
//
//  Channel   Direction  Handshake             Payload
//  -------   ---------  --------------------  ------------------------------------------
//  in        sink       in_valid / in_stall   kind, entry_index, entry_freq, entry_valid,
//                                             target_freq, relation
//  out       source     out_valid / out_stall selected_index, status
//  cfg       sink       cfg_write             cfg_index, cfg_data
//
// A query scans n entries, with n the entry count clipped to the table depth, one entry
// a cycle through the table's single read port and the shared compare unit; an exact
// match ends the scan early.
// Reset restores the configuration defaults; the table contents stay undefined until
// written, and there is no clearing pass.
// A result held by out_stall does not stop the next transfer in; a later query result
// waits in the finish state until the output register is free.
`default_nettype none

module freq_table_target_select_unit #(
    parameter int TABLE_DEPTH = ftts_pkg::DEF_TABLE_DEPTH,
    parameter int FREQ_BITS   = ftts_pkg::DEF_FREQ_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Input channel.
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 kind,
    input  wire logic [ftts_pkg::INDEX_BITS-1:0]      entry_index,
    input  wire logic [ftts_pkg::FIELD_FREQ_BITS-1:0] entry_freq,
    input  wire logic                                 entry_valid,
    input  wire logic [ftts_pkg::FIELD_FREQ_BITS-1:0] target_freq,
    input  wire logic [1:0]                           relation,
    // Output channel.
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [ftts_pkg::INDEX_BITS-1:0]           selected_index,
    output logic                                      status,
    // Configuration port.
    input  wire logic                                 cfg_write,
    input  wire logic [ftts_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [ftts_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SX = (AW > ftts_pkg::INDEX_BITS) ? AW : ftts_pkg::INDEX_BITS;

    ftts_pkg::scan_ctrl_t                ctrl;
    logic [AW-1:0]                       rd_addr;
    logic                                rd_live;
    logic [AW-1:0]                       rd_idx;
    logic [FREQ_BITS-1:0]                rd_freq;
    logic                                rd_valid;
    logic                                hit;
    logic                                found;
    logic [AW-1:0]                       sel_idx;
    logic [SX-1:0]                       sel_x;
    logic                                out_free;

    logic [ftts_pkg::LIMIT_BITS-1:0]     min_limit_reg;
    logic [ftts_pkg::LIMIT_BITS-1:0]     max_limit_reg;
    logic [ftts_pkg::COUNT_BITS-1:0]     entry_count_reg;

    logic                                out_valid_reg;
    logic [ftts_pkg::INDEX_BITS-1:0]     selected_index_reg;
    logic                                status_reg;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_limit_reg   <= '0;
            max_limit_reg   <= ftts_pkg::MAX_LIMIT_RESET;
            entry_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == ftts_pkg::CFG_MIN_LIMIT)
                min_limit_reg <= ftts_pkg::LIMIT_BITS'(cfg_data);
            if (cfg_index == ftts_pkg::CFG_MAX_LIMIT)
                max_limit_reg <= ftts_pkg::LIMIT_BITS'(cfg_data);
            if (cfg_index == ftts_pkg::CFG_ENTRY_COUNT)
                entry_count_reg <= cfg_data[ftts_pkg::COUNT_BITS-1:0];
        end
    end

    // Sequencer.
    ftts_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .kind        (kind),
        .entry_count (entry_count_reg),
        .hit         (hit),
        .rd_live     (rd_live),
        .out_free    (out_free),
        .ctrl        (ctrl),
        .rd_addr     (rd_addr)
    );

    // Frequency table.
    ftts_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FREQ_BITS   (FREQ_BITS)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (ctrl.wr_en),
        .entry_index (entry_index),
        .entry_freq  (entry_freq),
        .entry_valid (entry_valid),
        .rd_en       (ctrl.rd_en),
        .rd_addr     (rd_addr),
        .rd_live     (rd_live),
        .rd_idx      (rd_idx),
        .rd_freq     (rd_freq),
        .rd_valid    (rd_valid)
    );

    // Shared compare unit.
    ftts_eval #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FREQ_BITS   (FREQ_BITS)
    ) u_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (ctrl.query_start),
        .relation    (relation),
        .target_freq (target_freq),
        .min_limit   (min_limit_reg),
        .max_limit   (max_limit_reg),
        .rd_live     (rd_live),
        .rd_idx      (rd_idx),
        .rd_freq     (rd_freq),
        .rd_valid    (rd_valid),
        .hit         (hit),
        .found       (found),
        .sel_idx     (sel_idx)
    );

    // Output register: free when empty or when its transfer completes now.
    assign out_free = !out_valid_reg || !out_stall;
    assign sel_x    = SX'(sel_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            selected_index_reg <= sel_x[ftts_pkg::INDEX_BITS-1:0];
            status_reg         <= found ? ftts_pkg::STATUS_FOUND : ftts_pkg::STATUS_NONE;
        end
    end

    assign in_stall       = ctrl.stall;
    assign out_valid      = out_valid_reg;
    assign selected_index = selected_index_reg;
    assign status         = status_reg;

endmodule

`default_nettype wire

// ===== sim/freq_table_target_select_unit_test.sv =====
// Self-checking testbench for the frequency table target select unit.
`timescale 1ns / 1ps

module freq_table_target_select_unit_test;
    import ftts_pkg::*;

    localparam int DEPTH          = DEF_TABLE_DEPTH;
    localparam int SETTLE_CYCLES  = DEPTH + 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1880;
    localparam logic [23:0] FREQ_TOP = 24'hFFFFFF;

    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic                  status;
    } pick_t;

    // Clock, reset and block signals.
    logic                       clk;
    logic                       rst_n          = 1'b0;
    logic                       in_valid       = 1'b0;
    logic                       in_stall;
    kind_t                      kind           = KIND_WRITE;
    logic [INDEX_BITS-1:0]      entry_index    = '0;
    logic [FIELD_FREQ_BITS-1:0] entry_freq     = '0;
    logic                       entry_valid    = 1'b0;
    logic [FIELD_FREQ_BITS-1:0] target_freq    = '0;
    rel_t                       relation       = REL_AT_ABOVE;
    logic                       out_valid;
    logic                       out_stall      = 1'b0;
    logic [INDEX_BITS-1:0]      selected_index;
    logic                       status;
    logic                       cfg_write      = 1'b0;
    logic [CFG_INDEX_BITS-1:0]  cfg_index      = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_data       = '0;

    // Shadow copy of the table and the policy registers.
    logic [23:0]      shadow_freq [DEPTH];
    logic             shadow_usable [DEPTH];
    bit [DEPTH-1:0]   written_mask = '0;
    logic [23:0]      pol_min   = 24'd0;
    logic [23:0]      pol_max   = MAX_LIMIT_RESET;
    logic [5:0]       pol_count = 6'd0;

    // Expected query answers, oldest first.
    pick_t expected_picks[$];

    // Bookkeeping.
    int  errors       = 0;
    int  n_writes     = 0;
    int  n_rel [4]    = '{0, 0, 0, 0};
    int  n_found      = 0;
    int  n_none       = 0;
    int  n_policies   = 0;
    int  idle_cycles  = 0;
    bit  steady       = 1'b0;

    // Grid that random frequencies and targets are drawn from.
    logic [23:0] g_base;
    logic [23:0] g_step;

    freq_table_target_select_unit DUT (.*);

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Report one mismatch and count it.
    task automatic report_mismatch(string msg);
        errors++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Work out the answer the block should give for a query.
    function automatic pick_t select_entry(logic [23:0] target, rel_t rel);
        pick_t       res;
        int          n;
        bit          have_best;
        bit          have_alt;
        logic [23:0] best_key;
        logic [23:0] best_f;
        logic [23:0] alt_key;
        logic [23:0] f;
        logic [23:0] gap;
        logic [4:0]  best_idx;
        logic [4:0]  alt_idx;
        res.index = '0;
        res.status = STATUS_NONE;
        n = (int'(pol_count) > DEPTH) ? DEPTH : int'(pol_count);
        have_best = 1'b0;
        have_alt = 1'b0;
        best_key = '0;
        best_f = '0;
        alt_key = '0;
        best_idx = '0;
        alt_idx = '0;
        for (int i = 0; i < n; i++)
        begin
            f = shadow_freq[i];
            if (!shadow_usable[i])
                continue;
            // Exact mode takes the first usable equal entry, window or not.
            if (rel == REL_EXACT)
            begin
                if (f == target)
                begin
                    res.index = 5'(i);
                    res.status = STATUS_FOUND;
                    return res;
                end
                continue;
            end
            if (f < pol_min || f > pol_max)
                continue;
            if (f == target)
            begin
                res.index = 5'(i);
                res.status = STATUS_FOUND;
                return res;
            end
            case (rel)
                REL_AT_ABOVE:
                begin
                    if (f > target)
                    begin
                        if (!have_best || f <= best_key)
                        begin
                            have_best = 1'b1; best_key = f; best_idx = 5'(i);
                        end
                    end
                    else if (!have_alt || f >= alt_key)
                    begin
                        have_alt = 1'b1; alt_key = f; alt_idx = 5'(i);
                    end
                end
                REL_AT_BELOW:
                begin
                    if (f < target)
                    begin
                        if (!have_best || f >= best_key)
                        begin
                            have_best = 1'b1; best_key = f; best_idx = 5'(i);
                        end
                    end
                    else if (!have_alt || f <= alt_key)
                    begin
                        have_alt = 1'b1; alt_key = f; alt_idx = 5'(i);
                    end
                end
                default:
                begin
                    // Closest: a distance tie goes to the higher frequency.
                    gap = (f > target) ? f - target : target - f;
                    if (!have_best || gap < best_key || (gap == best_key && f > best_f))
                    begin
                        have_best = 1'b1; best_key = gap; best_f = f; best_idx = 5'(i);
                    end
                end
            endcase
        end
        if (have_best)
        begin
            res.index = best_idx;
            res.status = STATUS_FOUND;
        end
        else if (have_alt)
        begin
            res.index = alt_idx;
            res.status = STATUS_FOUND;
        end
        return res;
    endfunction

    // Send one item over the input channel and record what it should cause.
    task automatic send_item(kind_t k, logic [4:0] idx, logic [23:0] ef, logic ev,
                             logic [23:0] tf, rel_t rel);
        while (!steady && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        entry_index <= idx;
        entry_freq  <= ef;
        entry_valid <= ev;
        target_freq <= tf;
        relation    <= rel;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // The transfer happened at this edge.
        if (k == KIND_WRITE)
        begin
            shadow_freq[idx] = ef;
            shadow_usable[idx] = ev;
            written_mask[idx] = 1'b1;
            n_writes++;
        end
        else
        begin
            expected_picks.push_back(select_entry(tf, rel));
            n_rel[int'(rel)]++;
        end
    endtask

    // Let every query finish and the block settle before the policy changes.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three policy registers, one per cycle.
    task automatic apply_policy(logic [23:0] lo, logic [23:0] hi, logic [5:0] count);
        cfg_write <= 1'b1;
        cfg_index <= CFG_MIN_LIMIT;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_MAX_LIMIT;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= CFG_ENTRY_COUNT;
        cfg_data  <= CFG_DATA_BITS'(count);
        @(posedge clk);
        cfg_write <= 1'b0;
        pol_min = lo;
        pol_max = hi;
        pol_count = count;
        n_policies++;
        @(posedge clk);
    endtask

    // A frequency near the current grid, now and then an extreme or anything at all.
    function automatic logic [23:0] grid_freq();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return 24'(g_base + g_step * $urandom_range(0, 7));
        else if (r < 87)
            return $urandom_range(1) ? FREQ_TOP : 24'd0;
        else
            return 24'($urandom);
    endfunction

    // A target on the grid, half way between grid points, or anywhere.
    function automatic logic [23:0] grid_target();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return 24'(g_base + g_step * $urandom_range(0, 8));
        else if (r < 75)
            return 24'(g_base + g_step * $urandom_range(0, 7) + (g_step >> 1));
        else if (r < 85)
            return $urandom_range(1) ? FREQ_TOP : 24'd0;
        else
            return 24'($urandom);
    endfunction

    // Fill every position in use that has not been written yet.
    task automatic fill_missing_entries();
        int n;
        n = (int'(pol_count) > DEPTH) ? DEPTH : int'(pol_count);
        for (int i = 0; i < n; i++)
            if (!written_mask[i])
                send_item(KIND_WRITE, 5'(i), grid_freq(), 1'($urandom_range(3) != 0),
                          24'($urandom), rel_t'($urandom_range(3)));
    endtask

    // Load a small table with duplicates, an invalid entry and both extremes.
    task automatic test_table_load();
        apply_policy(24'd0, FREQ_TOP, 6'd6);
        send_item(KIND_WRITE, 5'd0, 24'd0,    1'b1, 24'd0, REL_AT_ABOVE);
        send_item(KIND_WRITE, 5'd1, 24'd1000, 1'b1, 24'd0, REL_AT_ABOVE);
        send_item(KIND_WRITE, 5'd2, 24'd2000, 1'b1, 24'd0, REL_AT_ABOVE);
        send_item(KIND_WRITE, 5'd3, 24'd2000, 1'b1, 24'd0, REL_AT_ABOVE);
        send_item(KIND_WRITE, 5'd4, 24'd3000, 1'b0, 24'd0, REL_AT_ABOVE);
        send_item(KIND_WRITE, 5'd5, FREQ_TOP, 1'b1, FREQ_TOP, REL_EXACT);
    endtask

    // Every relation with the window wide open, including ties and equal entries.
    task automatic test_relations_open_window();
        send_item(KIND_QUERY, 5'd0, 24'd0, 1'b0, 24'd2000, REL_EXACT);
        send_item(KIND_QUERY, 5'd0, 24'd0, 1'b0, 24'd3000, REL_EXACT);
        send_item(KIND_QUERY, 5'd0, 24'd0, 1'b0, 24'd1500, REL_AT_ABOVE);
        send_item(KIND_QUERY, 5'd0, 24'd0, 1'b0, 24'd2500, REL_AT_BELOW);
        send_item(KIND_QUERY, 5'd0, 24'd0, 1'b0, 24'd1500, REL_CLOSEST);
        send_item(KIND_QUERY, 5'd0, 24'd0, 1'b0, FREQ_TOP, REL_AT_ABOVE);
        send_item(KIND_QUERY, 5'd0, 24'd0, 1'b0, 24'd0,    REL_AT_BELOW);
        send_item(KIND_QUERY, 5'd0, 24'd0, 1'b0, 24'd0,    REL_CLOSEST);
    endtask

    // A narrow window forces the fall-back directions; exact mode ignores it.
    task automatic test_relations_narrow_window();
        wait_idle();
        apply_policy(24'd1000, 24'd2000, 6'd6);
        send_item(KIND_QUERY, 5'd0, 24'd0, 1'b0, 24'd2500, REL_AT_ABOVE);
        send_item(KIND_QUERY, 5'd0, 24'd0, 1'b0, 24'd500,  REL_AT_BELOW);
        send_item(KIND_QUERY, 5'd0, 24'd0, 1'b0, 24'd0,    REL_EXACT);
        send_item(KIND_QUERY, 5'd0, 24'd0, 1'b0, FREQ_TOP, REL_CLOSEST);
    endtask

    // An empty window gives no match except in exact mode, which ignores it; an empty table gives none.
    task automatic test_empty_window_and_count();
        wait_idle();
        apply_policy(24'd2000, 24'd1000, 6'd6);
        send_item(KIND_QUERY, 5'd0, 24'd0, 1'b0, 24'd1500, REL_AT_ABOVE);
        send_item(KIND_QUERY, 5'd0, 24'd0, 1'b0, 24'd2000, REL_EXACT);
        wait_idle();
        apply_policy(24'd0, FREQ_TOP, 6'd0);
        send_item(KIND_QUERY, 5'd0, 24'd0, 1'b0, 24'd1000, REL_CLOSEST);
    endtask

    // Phases of random policy, table updates and queries on a shared frequency grid.
    task automatic test_random_traffic();
        int          sent;
        int          phase;
        int          phase_len;
        int          n_used;
        int          r;
        logic [23:0] lo;
        logic [23:0] hi;
        logic [23:0] tmp;
        logic [5:0]  count;
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // Pick a grid, then a window and a count drawn from it.
            r = $urandom_range(9);
            g_step = (r == 0) ? 24'd1 : 24'($urandom_range(2, 4000));
            r = $urandom_range(9);
            if (r == 0)
                g_base = 24'd0;
            else if (r == 1)
                g_base = FREQ_TOP - 24'($urandom_range(0, 3000));
            else
                g_base = 24'($urandom);
            r = $urandom_range(9);
            case (r)
                0:
                begin
                    lo = 24'd0;
                    hi = FREQ_TOP;
                end
                1:
                begin
                    hi = grid_freq();
                    lo = hi + 24'd1;
                end
                2:
                begin
                    lo = grid_freq();
                    hi = lo;
                end
                3:
                begin
                    lo = FREQ_TOP;
                    hi = FREQ_TOP;
                end
                default:
                begin
                    lo = grid_target();
                    hi = grid_target();
                    if (lo > hi)
                    begin
                        tmp = lo;
                        lo = hi;
                        hi = tmp;
                    end
                end
            endcase
            r = $urandom_range(99);
            if (r < 8)
                count = 6'd0;
            else if (r < 22)
                count = 6'($urandom_range(DEPTH + 1, 63));
            else
                count = 6'($urandom_range(1, DEPTH));
            steady = (phase >= 10 && phase < 15);
            wait_idle();
            apply_policy(lo, hi, count);
            fill_missing_entries();
            n_used = (int'(count) > DEPTH) ? DEPTH : int'(count);
            phase_len = $urandom_range(20, 60);
            for (int j = 0; j < phase_len; j++)
            begin
                r = $urandom_range(99);
                if (r < 45)
                    send_item(KIND_QUERY, 5'($urandom), 24'($urandom), 1'($urandom),
                              grid_target(), rel_t'($urandom_range(3)));
                else if (r < 80)
                    send_item(KIND_WRITE,
                              (n_used > 0 && $urandom_range(3) != 0) ?
                                  5'($urandom_range(0, n_used - 1)) : 5'($urandom),
                              grid_freq(), 1'($urandom_range(4) != 0),
                              24'($urandom), rel_t'($urandom_range(3)));
                else
                    send_item(kind_t'($urandom_range(1)), 5'($urandom), 24'($urandom),
                              1'($urandom), 24'($urandom), rel_t'($urandom_range(3)));
            end
            sent += phase_len;
            phase++;
        end
        steady = 1'b0;
    endtask

    // Output side: random stall, except during the steady stretch.
    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(99) < 7);

    // Compare every result transfer with the oldest expected answer.
    always @(posedge clk)
    begin : check_results
        pick_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_picks.size() == 0)
                report_mismatch("result transfer with no query waiting");
            else
            begin
                want = expected_picks.pop_front();
                if (selected_index !== want.index)
                    report_mismatch($sformatf("selected_index %0d, expected %0d",
                                              selected_index, want.index));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0b, expected %0b",
                                              status, want.status));
                if (want.status == STATUS_FOUND)
                    n_found++;
                else
                    n_none++;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles, %0d answers outstanding",
                     WATCHDOG_LIMIT, expected_picks.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_load();
        test_relations_open_window();
        test_relations_narrow_window();
        test_empty_window_and_count();
        test_random_traffic();
        wait_idle();
        $display("Covered %0d table writes and %0d queries (%0d at/above, %0d at/below,",
                 n_writes, n_rel[0] + n_rel[1] + n_rel[2] + n_rel[3],
                 n_rel[0], n_rel[1]);
        $display("%0d closest, %0d exact) over %0d policies: %0d found, %0d no match.",
                 n_rel[2], n_rel[3], n_policies, n_found, n_none);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
